>>> rtl/jtl_pkg.sv
package jtl_pkg;

  // Byte codes the lexer reacts to or produces.
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowN      = 8'h6e;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChOpenObj   = 8'h7b;
  localparam logic [7:0] ChCloseObj  = 8'h7d;
  localparam logic [7:0] ChOpenArr   = 8'h5b;
  localparam logic [7:0] ChCloseArr  = 8'h5d;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChReturn    = 8'h0d;

  // Multiplier of the decimal accumulator.
  localparam logic [31:0] Radix = 32'd10;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_STR  = 2'd2,
    MODE_ESC  = 2'd3
  } lex_mode_e;

  typedef enum logic [2:0] {
    TOK_NUMBER    = 3'd0,
    TOK_STR_CHAR  = 3'd1,
    TOK_STR_END   = 3'd2,
    TOK_OPEN_OBJ  = 3'd3,
    TOK_CLOSE_OBJ = 3'd4,
    TOK_OPEN_ARR  = 3'd5,
    TOK_CLOSE_ARR = 3'd6
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic [31:0] value;
    logic        last;
  } token_t;

  // Everything one lexer step produces from one byte.
  typedef struct packed {
    lex_mode_e   mode;
    logic [31:0] acc;
    logic [1:0]  count;
    token_t      tok0;
    token_t      tok1;
  } step_t;

endpackage

>>> rtl/jtl_if.sv
interface jtl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface jtl_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [31:0] token_value;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_value,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_value,
                input last_of_run, output ready);
endinterface

>>> rtl/json_token_lexer.sv
// Channel  Direction  Payload                                 Transaction
// in_if    sink       byte_in[7:0]                            valid && ready
// out_if   source     token_kind[2:0] token_value[31:0]       valid && ready
//                     last_of_run
//
// A byte is registered on acceptance and lexed once the four-entry token queue
// has room for two tokens, which then enter the queue.
// One byte per cycle is taken while the queue has room for two tokens; the queue
// gives out at most one token per cycle, and only while the output is ready.
// Reset clears the lexer mode, accumulator, input stage and queue pointers.
// A stalled output fills the queue and then holds the input ready low.
module json_token_lexer (
  input logic        clk_i,
  input logic        rst_ni,
  jtl_byte_if.sink   in_if,
  jtl_token_if.source out_if
);
  import jtl_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic          stg_valid_q, stg_valid_d;
  logic [7:0]    stg_byte_q;
  lex_mode_e     mode_q, mode_d;
  logic [31:0]   acc_q, acc_d;
  step_t         step;
  logic          advance;
  logic          in_take;
  logic          pop;
  logic [1:0]    push_n;

  token_t        fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // The staged byte is lexed once the queue can take two tokens.
  assign advance      = stg_valid_q && (count_q <= CntW'(Depth - 2));
  assign in_if.ready  = !stg_valid_q || advance;
  assign in_take      = in_if.valid && in_if.ready;
  assign stg_valid_d  = in_take || (stg_valid_q && !advance);

  jtl_step u_step (
    .mode_i (mode_q),
    .acc_i  (acc_q),
    .byte_i (stg_byte_q),
    .step_o (step)
  );

  assign mode_d = advance ? step.mode : mode_q;
  assign acc_d  = advance ? step.acc  : acc_q;

  // Queue bookkeeping.
  assign pop      = out_if.valid && out_if.ready;
  assign push_n   = advance ? step.count : 2'd0;
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_n);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      acc_q       <= 32'd0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      mode_q      <= mode_d;
      acc_q       <= acc_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stg_byte_q <= in_if.byte_in;
    end
  end

  // Token storage; the second token goes to the slot after the first.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= step.tok0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= step.tok1;
    end
  end

  // Output from the queue head.
  assign out_if.valid       = (count_q != '0);
  assign out_if.token_kind  = fifo_q[rd_ptr_q].kind;
  assign out_if.token_value = fifo_q[rd_ptr_q].value;
  assign out_if.last_of_run = fifo_q[rd_ptr_q].last;

  // The queue never holds more tokens than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("token queue overflow");

  // A two-token step grows the queue by two, less any token taken out.
  a_two_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step.count == 2'd2 && !pop) |=> count_q == $past(count_q) + CntW'(2))
    else $error("two-token step not stored");

  // Only a staged byte can change the lexer mode.
  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> mode_q == $past(mode_q) && acc_q == $past(acc_q))
    else $error("lexer state changed without a byte");

  // The escape mode is only entered from inside a string.
  a_esc_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step.mode == MODE_ESC) |-> mode_q == MODE_STR)
    else $error("escape outside a string");

endmodule

>>> rtl/jtl_step.sv
module jtl_step (
  input  jtl_pkg::lex_mode_e mode_i,
  input  logic [31:0]        acc_i,
  input  logic [7:0]         byte_i,
  output jtl_pkg::step_t     step_o
);
  import jtl_pkg::*;

  logic        is_digit;
  logic [31:0] digit_val;
  logic        struct_hit;
  token_kind_e struct_kind;
  logic [7:0]  esc_char;
  token_t      struct_tok;

  // Byte classification shared by the number and idle modes.
  assign is_digit  = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign digit_val = {24'd0, byte_i - ChZero};

  always_comb begin
    struct_hit  = 1'b1;
    struct_kind = TOK_OPEN_OBJ;
    case (byte_i)
      ChOpenObj:  struct_kind = TOK_OPEN_OBJ;
      ChCloseObj: struct_kind = TOK_CLOSE_OBJ;
      ChOpenArr:  struct_kind = TOK_OPEN_ARR;
      ChCloseArr: struct_kind = TOK_CLOSE_ARR;
      default:    struct_hit = 1'b0;
    endcase
  end

  assign struct_tok = '{kind: struct_kind, value: 32'd0, last: 1'b0};

  // Escape letters map to control characters; any other byte is literal.
  always_comb begin
    case (byte_i)
      ChLowT:  esc_char = ChTab;
      ChLowN:  esc_char = ChNewline;
      ChLowR:  esc_char = ChReturn;
      default: esc_char = byte_i;
    endcase
  end

  // Next state and up to two tokens for this byte.
  always_comb begin
    step_o       = '0;
    step_o.mode  = mode_i;
    step_o.acc   = acc_i;
    step_o.tok0  = '{kind: TOK_NUMBER, value: 32'd0, last: 1'b0};
    step_o.tok1  = '{kind: TOK_NUMBER, value: 32'd0, last: 1'b0};
    case (mode_i)
      MODE_NUM: begin
        if (is_digit) begin
          step_o.acc = acc_i * Radix + digit_val;
        end else begin
          // The number ends; the byte is then handled as between tokens.
          step_o.tok0  = '{kind: TOK_NUMBER, value: acc_i, last: 1'b0};
          step_o.count = 2'd1;
          step_o.mode  = MODE_IDLE;
          if (byte_i == ChQuote) begin
            step_o.mode = MODE_STR;
          end else if (struct_hit) begin
            step_o.tok1  = struct_tok;
            step_o.count = 2'd2;
          end
        end
      end
      MODE_STR: begin
        if (byte_i == ChQuote) begin
          step_o.tok0  = '{kind: TOK_STR_END, value: 32'd0, last: 1'b0};
          step_o.count = 2'd1;
          step_o.mode  = MODE_IDLE;
        end else if (byte_i == ChBackslash) begin
          step_o.mode = MODE_ESC;
        end else begin
          step_o.tok0  = '{kind: TOK_STR_CHAR, value: {24'd0, byte_i}, last: 1'b0};
          step_o.count = 2'd1;
        end
      end
      MODE_ESC: begin
        step_o.tok0  = '{kind: TOK_STR_CHAR, value: {24'd0, esc_char}, last: 1'b0};
        step_o.count = 2'd1;
        step_o.mode  = MODE_STR;
      end
      default: begin
        if (is_digit) begin
          step_o.acc  = digit_val;
          step_o.mode = MODE_NUM;
        end else if (byte_i == ChQuote) begin
          step_o.mode = MODE_STR;
        end else if (struct_hit) begin
          step_o.tok0  = struct_tok;
          step_o.count = 2'd1;
        end
      end
    endcase

    // Mark the final token of this byte.
    if (step_o.count == 2'd1) begin
      step_o.tok0.last = 1'b1;
    end else if (step_o.count == 2'd2) begin
      step_o.tok1.last = 1'b1;
    end
  end

endmodule
